/* sv/tarp_pkg.sv */
// Shared types, constants and the LFSR helper function of the triad arpeggiator.
package tarp_pkg;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  // Configuration port.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Field and state widths.
  localparam int HELD_W = 7;
  localparam int NOTE_W = 8;
  localparam int STEP_W = 2;
  localparam int SPAN_W = 4;
  localparam int LFSR_W = 16;

  // Default octave limit, handed to the top level parameter.
  localparam int MAX_OCTAVES_DEF = 8;

  // Remainder unit: one digit of the dividend is folded in per cycle.
  localparam int DIGIT_W   = 4;
  localparam int DIV_STEPS = LFSR_W / DIGIT_W;
  localparam int DIV_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // Register indices (address bits [3:2]).
  localparam logic [1:0] REG_RATE   = 2'd0;
  localparam logic [1:0] REG_MODE   = 2'd1;
  localparam logic [1:0] REG_SPAN   = 2'd2;
  localparam logic [1:0] REG_REPEAT = 2'd3;

  // Stepping patterns.
  localparam logic [1:0] MODE_UP     = 2'd0;
  localparam logic [1:0] MODE_DOWN   = 2'd1;
  localparam logic [1:0] MODE_UPDOWN = 2'd2;
  localparam logic [1:0] MODE_RANDOM = 2'd3;

  // Chord steps.
  localparam logic [STEP_W-1:0] STEP_ROOT  = 2'd0;
  localparam logic [STEP_W-1:0] STEP_THIRD = 2'd1;
  localparam logic [STEP_W-1:0] STEP_FIFTH = 2'd2;
  localparam logic [SPAN_W-1:0] CHORD_STEPS = 4'd3;

  // Musical constants.
  localparam logic [NOTE_W-1:0] THIRD_OFFSET    = 8'd4;
  localparam logic [NOTE_W-1:0] FIFTH_OFFSET    = 8'd7;
  localparam logic [NOTE_W-1:0] OCTAVE_SEMIS    = 8'd12;
  localparam logic [NOTE_W-1:0] LOWEST_PLAYABLE = 8'd8;

  // Reset values.
  localparam logic [1:0]        RATE_RST  = 2'd1;
  localparam logic [1:0]        MODE_RST  = MODE_RANDOM;
  localparam logic [SPAN_W-1:0] SPAN_RST  = 4'd1;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW_OCT,
    ST_DRAW_STEP,
    ST_EMIT
  } tarp_state_t;

  // Request to the remainder unit.
  typedef struct packed {
    logic                start;
    logic [LFSR_W-1:0]   dividend;
    logic [DIGIT_W-1:0]  divisor;
  } tarp_mod_req_t;

  // One shift of the Galois LFSR.
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] x);
    logic [LFSR_W-1:0] shifted;
    shifted = {1'b0, x[LFSR_W-1:1]};
    return x[0] ? (shifted ^ LFSR_TAPS) : shifted;
  endfunction

endpackage

/* sv/tarp_mod_unit.sv */
// Iterative remainder unit: dividend modulo a small divisor, one digit per cycle.
module tarp_mod_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  tarp_pkg::tarp_mod_req_t       req,
  output logic                          done,
  output logic [tarp_pkg::DIGIT_W-1:0]  remainder
);
  import tarp_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [LFSR_W-1:0]    shreg;
  logic [DIGIT_W-1:0]   divisor;
  logic [DIGIT_W-1:0]   remainder_next;

  // Fold the top digit of the shift register into the running remainder.
  always_comb begin
    logic [DIGIT_W:0] r;
    r = {1'b0, remainder};
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      r = {r[DIGIT_W-1:0], shreg[LFSR_W-DIGIT_W+i]};
      if (r >= {1'b0, divisor}) begin
        r = r - {1'b0, divisor};
      end
    end
    remainder_next = r[DIGIT_W-1:0];
  end

  // Control: a start loads the operands, then the digits are walked through.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      shreg     <= req.dividend;
      divisor   <= req.divisor;
      remainder <= '0;
    end else if (busy) begin
      shreg     <= {shreg[LFSR_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      remainder <= remainder_next;
    end
  end

endmodule

/* sv/triad_arpeggiator.sv */
// Top level of the triad arpeggiator: stream ports, register file and step sequencer.
// A tick that does not fire leaves the sequencer idle. A firing tick in up, down or up-down
// mode goes to the emit state, which loads a playable note once the output register is free.
// In random mode it first makes two draws, octave then chord step, on the shared
// one-digit-per-cycle remainder unit. Input ticks are refused until the sequencer is idle.
// Synchronous active-high reset restores the configuration registers, the pattern state and the LFSR seed.
module triad_arpeggiator #(
  parameter int MAX_OCTAVES = tarp_pkg::MAX_OCTAVES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input beat: [0] tick_thirtysecond, [1] tick_sixteenth, [2] tick_eighth,
  // [3] tick_quarter, [10:4] held_note, [15:11] zero
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [tarp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // Output beat: [7:0] play_note
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [tarp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tarp_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tarp_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tarp_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import tarp_pkg::*;

  localparam int OCT_W = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam logic [SPAN_W-1:0] SPAN_MAX = SPAN_W'(MAX_OCTAVES);

  // Configuration registers.
  logic [1:0]        rate_select;
  logic [1:0]        pattern_mode;
  logic [SPAN_W-1:0] octave_span;
  logic              repeat_root_only;

  // Pattern state.
  tarp_state_t        state, state_next;
  logic [STEP_W-1:0]  chord_step, chord_step_next;
  logic [OCT_W-1:0]   octave_now, octave_now_next;
  logic               going_down, going_down_next;
  logic [LFSR_W-1:0]  random_lfsr, random_lfsr_next;
  logic [NOTE_W-1:0]  note_out, note_out_next;
  logic               note_play, note_play_next;
  logic               out_load;

  // Remainder unit connection.
  tarp_mod_req_t      mod_req;
  logic               mod_done;
  logic [DIGIT_W-1:0] mod_rem;

  // Combinational views of the input beat.
  logic [3:0]         ticks;
  logic [HELD_W-1:0]  held_note;
  logic               fire;
  logic [SPAN_W-1:0]  span_eff;
  logic [SPAN_W-1:0]  oct_top;
  logic [OCT_W-1:0]   oct_c;
  logic [SPAN_W-1:0]  oct_w;
  logic [NOTE_W-1:0]  note_offset;
  logic [NOTE_W-1:0]  note_base;
  logic               apb_write;

  assign ticks     = s_axis_tdata[3:0];
  assign held_note = s_axis_tdata[HELD_W+3:4];
  assign s_axis_tready = (state == ST_IDLE);
  assign fire = s_axis_tvalid && s_axis_tready && ticks[rate_select];

  // Configuration port: writes in the access phase, reads straight from the registers.
  assign pready    = 1'b1;
  assign apb_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_RATE:   prdata = APB_DATA_W'(rate_select);
      REG_MODE:   prdata = APB_DATA_W'(pattern_mode);
      REG_SPAN:   prdata = APB_DATA_W'(octave_span);
      REG_REPEAT: prdata = APB_DATA_W'(repeat_root_only);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_select      <= RATE_RST;
      pattern_mode     <= MODE_RST;
      octave_span      <= SPAN_RST;
      repeat_root_only <= 1'b0;
    end else if (apb_write) begin
      case (paddr[3:2])
        REG_RATE:   rate_select      <= pwdata[1:0];
        REG_MODE:   pattern_mode     <= pwdata[1:0];
        REG_SPAN:   octave_span      <= pwdata[SPAN_W-1:0];
        REG_REPEAT: repeat_root_only <= pwdata[0];
        default:    ;
      endcase
    end
  end

  // Effective span and the octave saturated into it.
  always_comb begin
    if (octave_span == '0) begin
      span_eff = SPAN_W'(1);
    end else if (octave_span > SPAN_MAX) begin
      span_eff = SPAN_MAX;
    end else begin
      span_eff = octave_span;
    end
    oct_top = span_eff - 1'b1;
    oct_c   = (SPAN_W'(octave_now) > oct_top) ? OCT_W'(oct_top) : octave_now;
    oct_w   = SPAN_W'(oct_c);
  end

  // Chord note before the octave offset.
  always_comb begin
    note_offset = '0;
    if (!repeat_root_only) begin
      case (chord_step)
        STEP_THIRD: note_offset = THIRD_OFFSET;
        STEP_FIFTH: note_offset = FIFTH_OFFSET;
        default:    note_offset = '0;
      endcase
    end
    note_base = NOTE_W'(held_note) + note_offset;
  end

  // Sequencer: next state, pattern advance and remainder unit requests.
  always_comb begin
    state_next       = state;
    chord_step_next  = chord_step;
    octave_now_next  = octave_now;
    going_down_next  = going_down;
    random_lfsr_next = random_lfsr;
    note_out_next    = note_out;
    note_play_next   = note_play;
    out_load         = 1'b0;
    mod_req.start    = 1'b0;
    mod_req.dividend = lfsr_next(random_lfsr);
    mod_req.divisor  = span_eff;

    case (state)
      ST_IDLE: begin
        if (fire) begin
          note_play_next  = (note_base > LOWEST_PLAYABLE);
          note_out_next   = note_base + OCTAVE_SEMIS * NOTE_W'(oct_c);
          octave_now_next = oct_c;
          state_next      = ST_EMIT;
          case (pattern_mode)
            MODE_UP: begin
              if (chord_step == STEP_FIFTH) begin
                octave_now_next = (oct_w == oct_top) ? '0 : OCT_W'(oct_w + 1'b1);
                chord_step_next = STEP_ROOT;
              end else begin
                chord_step_next = chord_step + 1'b1;
              end
            end
            MODE_DOWN: begin
              if (chord_step == STEP_ROOT) begin
                octave_now_next = (oct_w == '0) ? OCT_W'(oct_top) : OCT_W'(oct_w - 1'b1);
                chord_step_next = STEP_FIFTH;
              end else begin
                chord_step_next = chord_step - 1'b1;
              end
            end
            MODE_UPDOWN: begin
              if (!going_down) begin
                if (chord_step == STEP_FIFTH) begin
                  if (oct_w == oct_top) begin
                    going_down_next = 1'b1;
                  end else begin
                    octave_now_next = OCT_W'(oct_w + 1'b1);
                  end
                  chord_step_next = STEP_ROOT;
                end else begin
                  chord_step_next = chord_step + 1'b1;
                end
              end else begin
                if (chord_step == STEP_ROOT) begin
                  if (oct_w == '0) begin
                    going_down_next = 1'b0;
                  end else begin
                    octave_now_next = OCT_W'(oct_w - 1'b1);
                  end
                  chord_step_next = STEP_FIFTH;
                end else begin
                  chord_step_next = chord_step - 1'b1;
                end
              end
            end
            default: begin
              // Random: shift the LFSR and draw the octave first.
              random_lfsr_next = lfsr_next(random_lfsr);
              mod_req.start    = 1'b1;
              state_next       = ST_DRAW_OCT;
            end
          endcase
        end
      end

      ST_DRAW_OCT: begin
        if (mod_done) begin
          octave_now_next  = OCT_W'(mod_rem);
          random_lfsr_next = lfsr_next(random_lfsr);
          mod_req.start    = 1'b1;
          mod_req.divisor  = CHORD_STEPS;
          state_next       = ST_DRAW_STEP;
        end
      end

      ST_DRAW_STEP: begin
        if (mod_done) begin
          chord_step_next = STEP_W'(mod_rem);
          state_next      = ST_EMIT;
        end
      end

      ST_EMIT: begin
        // A low note is dropped; otherwise wait for the output register to free up.
        if (!note_play) begin
          state_next = ST_IDLE;
        end else if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer and pattern state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      chord_step  <= STEP_ROOT;
      octave_now  <= '0;
      going_down  <= 1'b0;
      random_lfsr <= LFSR_SEED;
    end else begin
      state       <= state_next;
      chord_step  <= chord_step_next;
      octave_now  <= octave_now_next;
      going_down  <= going_down_next;
      random_lfsr <= random_lfsr_next;
    end
  end

  // Note held between acceptance and emission.
  always_ff @(posedge clk) begin
    note_out  <= note_out_next;
    note_play <= note_play_next;
  end

  // Output register: the beat stays until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= note_out;
    end
  end

  // Shared remainder unit for the random draws.
  tarp_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .req       (mod_req),
    .done      (mod_done),
    .remainder (mod_rem)
  );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the triad arpeggiator with a note predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tarp_pkg::*;

  localparam int MAX_OCT     = MAX_OCTAVES_DEF;
  localparam int DRAIN       = 30;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 4000;
  localparam int PHASE_NOTES = 75;

  // Extra stress applied in the middle of a phase.
  typedef enum logic [1:0] {
    PRESS_NONE,
    PRESS_HOLD,
    PRESS_PAUSE
  } press_t;

  // Predicts the notes played and checks them in order.
  class arp_scoreboard;
    logic [1:0]        rate_sel;
    logic [1:0]        pattern;
    logic [SPAN_W-1:0] span_reg;
    logic              root_only;
    logic [STEP_W-1:0] step;
    logic [2:0]        octave;
    logic              descending;
    logic [LFSR_W-1:0] lfsr;
    logic [NOTE_W-1:0] notes_due[$];
    int                errors;

    function new();
      rate_sel   = RATE_RST;
      pattern    = MODE_RST;
      span_reg   = SPAN_RST;
      root_only  = 1'b0;
      step       = STEP_ROOT;
      octave     = 3'd0;
      descending = 1'b0;
      lfsr       = LFSR_SEED;
      errors     = 0;
    endfunction

    function void report(string msg);
      errors++;
      $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function int pending();
      return notes_due.size();
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_RATE:   rate_sel  = v[1:0];
        REG_MODE:   pattern   = v[1:0];
        REG_SPAN:   span_reg  = v[SPAN_W-1:0];
        REG_REPEAT: root_only = v[0];
        default: ;
      endcase
    endfunction

    // Galois shift, taken before every random draw.
    function logic [LFSR_W-1:0] lfsr_shift();
      logic low;
      low  = lfsr[0];
      lfsr = lfsr >> 1;
      if (low) lfsr = lfsr ^ LFSR_TAPS;
      return lfsr;
    endfunction

    // One accepted tick: work out the note, if any, and advance the pattern.
    function void note_tick(logic [IN_TDATA_W-1:0] d);
      logic [3:0]       flags;
      logic [HELD_W-1:0] held;
      int unsigned      eff_span;
      int unsigned      tone;
      flags = d[3:0];
      held  = d[10:4];
      if (!flags[rate_sel]) return;

      // Clamp the span and pull a stale octave back inside it.
      if (span_reg == 0) eff_span = 1;
      else if (span_reg > MAX_OCT) eff_span = MAX_OCT;
      else eff_span = span_reg;
      if (octave >= eff_span) octave = 3'(eff_span - 1);

      tone = held;
      if (!root_only) begin
        if (step == STEP_THIRD) tone = tone + THIRD_OFFSET;
        else if (step == STEP_FIFTH) tone = tone + FIFTH_OFFSET;
      end
      if (tone > LOWEST_PLAYABLE) notes_due.push_back(NOTE_W'(tone + OCTAVE_SEMIS * octave));

      case (pattern)
        MODE_UP: begin
          if (step == STEP_FIFTH) octave = 3'((octave + 1) % eff_span);
          step = (step == STEP_FIFTH) ? STEP_ROOT : step + 1'b1;
        end
        MODE_DOWN: begin
          if (step == STEP_ROOT) begin
            octave = (octave == 0) ? 3'(eff_span - 1) : octave - 1'b1;
            step   = STEP_FIFTH;
          end else begin
            step = step - 1'b1;
          end
        end
        MODE_UPDOWN: begin
          if (!descending) begin
            if (step == STEP_FIFTH) begin
              if (octave == eff_span - 1) descending = 1'b1;
              else octave = octave + 1'b1;
            end
            step = (step == STEP_FIFTH) ? STEP_ROOT : step + 1'b1;
          end else if (step == STEP_ROOT) begin
            // At the very bottom the direction turns without changing octave.
            if (octave == 0) descending = 1'b0;
            else octave = octave - 1'b1;
            step = STEP_FIFTH;
          end else begin
            step = step - 1'b1;
          end
        end
        default: begin
          octave = 3'(lfsr_shift() % eff_span);
          step   = STEP_W'(lfsr_shift() % CHORD_STEPS);
        end
      endcase
    endfunction

    function void check_note(logic [NOTE_W-1:0] got);
      logic [NOTE_W-1:0] want;
      if (notes_due.size() == 0) begin
        report($sformatf("note %0d played with none expected", got));
        return;
      end
      want = notes_due.pop_front();
      if (got !== want) report($sformatf("play_note %0d, expected %0d", got, want));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  arp_scoreboard sb;
  bit            calm;
  int            hold_ask;
  int            idle_cycles = 0;

  triad_arpeggiator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    return ($urandom_range(9) == 0) ? $urandom_range(50, 10) : $urandom_range(3, 1);
  endfunction

  function automatic logic [IN_TDATA_W-1:0] make_tick(logic [3:0] flags,
                                                       logic [HELD_W-1:0] held);
    return {5'b0, held, flags};
  endfunction

  // Output beats are checked before input beats of the same edge are noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_note(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_tick(s_axis_tdata);
    end
  end

  // Ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pwrite)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  initial begin : receiver
    int stall_left;
    int hold_done;
    stall_left = 0;
    hold_done  = 0;
    forever begin
      @(negedge clk);
      if (hold_ask != hold_done) begin
        hold_done  = hold_ask;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (calm || $urandom_range(99) < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall_left = pick_gap() - 1;
      end
    end
  end

  // Offers one tick after an optional gap; called and returning at a falling edge.
  task automatic send_tick(logic [IN_TDATA_W-1:0] d, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic sender_gap(output int gap);
    gap = (calm || $urandom_range(1)) ? 0 : pick_gap();
  endtask

  // Stops offering and waits for every expected note, then for the block to go quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (DRAIN) @(negedge clk);
  endtask

  // Register write with random bits above the field width; returns at a falling
  // edge with the bus still selected, so writes can follow each other directly.
  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    int w;
    case (idx)
      REG_SPAN:   w = SPAN_W;
      REG_REPEAT: w = 1;
      default:    w = 2;
    endcase
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= ({$urandom} << w) | value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic configure(logic [1:0] rate, logic [1:0] mode, int span, logic rep);
    reg_write(REG_RATE, 32'(rate));
    reg_write(REG_MODE, 32'(mode));
    reg_write(REG_SPAN, 32'(span));
    reg_write(REG_REPEAT, 32'(rep));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One phase of random ticks, counted in ticks that fire at the chosen rate.
  task automatic run_phase(logic [1:0] rate, logic [1:0] mode, int span, logic rep,
                           bit quiet, press_t press);
    int         fired;
    int         gap;
    logic [3:0] flags;
    logic [6:0] held;
    settle();
    configure(rate, mode, span, rep);
    calm  = quiet;
    fired = 0;
    while (fired < PHASE_NOTES) begin
      flags = 4'($urandom);
      if ($urandom_range(1)) flags[rate] = 1'b1;
      held = ($urandom_range(4) == 0) ? 7'($urandom_range(12)) : 7'($urandom);
      if (flags[rate]) begin
        fired++;
        if (fired == PHASE_NOTES / 2) begin
          if (press == PRESS_HOLD) begin
            hold_ask++;
          end else if (press == PRESS_PAUSE) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge clk); while (sb.pending() != 0);
          end
        end
      end
      sender_gap(gap);
      send_tick(make_tick(flags, held), gap);
    end
  endtask

  // Directed ticks, then phases that sweep the register settings.
  initial begin : stimulus
    logic [6:0] low_notes[12];
    sb = new();
    calm = 1'b1;
    hold_ask = 0;
    low_notes = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd5, 7'd8, 7'd9, 7'd100, 7'd127, 7'd4,
                  7'd6, 7'd12};
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: sixteenth rate, random pattern, single octave.
    send_tick(make_tick(4'b0000, 7'd60), 0);
    send_tick(make_tick(4'b1101, 7'd60), 0);
    send_tick(make_tick(4'b0010, 7'd0), 0);
    send_tick(make_tick(4'b0010, 7'd127), 0);
    send_tick(make_tick(4'b1111, 7'd127), 0);
    send_tick(make_tick(4'b0010, 7'd8), 0);
    send_tick(make_tick(4'b0010, 7'd9), 0);
    send_tick(make_tick(4'b0010, 7'd1), 0);
    send_tick(make_tick(4'b0010, 7'd5), 0);
    send_tick(make_tick(4'b1110, 7'd2), 0);

    // Up-down over one octave, so the pattern turns at the bottom and top.
    settle();
    configure(2'd0, MODE_UPDOWN, 1, 1'b0);
    foreach (low_notes[i]) send_tick(make_tick(4'b0001, low_notes[i]), 0);

    run_phase(2'd0, MODE_UP,     1,  1'b0, 1'b0, PRESS_NONE);
    run_phase(2'd3, MODE_DOWN,   8,  1'b0, 1'b0, PRESS_PAUSE);
    run_phase(2'd2, MODE_UPDOWN, 3,  1'b0, 1'b1, PRESS_NONE);
    run_phase(2'd1, MODE_RANDOM, 8,  1'b0, 1'b0, PRESS_HOLD);
    run_phase(2'd0, MODE_UP,     2,  1'b1, 1'b0, PRESS_NONE);
    run_phase(2'd3, MODE_UPDOWN, 0,  1'b0, 1'b0, PRESS_HOLD);
    run_phase(2'd1, MODE_RANDOM, 15, 1'b1, 1'b0, PRESS_NONE);
    run_phase(2'd2, MODE_DOWN,   5,  1'b0, 1'b0, PRESS_PAUSE);
    run_phase(2'd3, MODE_RANDOM, 3,  1'b0, 1'b0, PRESS_NONE);
    run_phase(2'd0, MODE_UPDOWN, 8,  1'b1, 1'b0, PRESS_NONE);

    // Drain and give the verdict.
    settle();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/tarp_pkg.sv
sv/tarp_mod_unit.sv
sv/triad_arpeggiator.sv
tb/tb.sv
